// ----- design/wmv_pkg.sv -----
// Shared types and constants of the window mean and variance monitor.
`default_nettype none
package wmv_pkg;

	localparam int unsigned SAMPLE_W   = 10;
	localparam int unsigned MEAN_W     = 10;
	localparam int unsigned VAR_W      = 15;
	localparam int unsigned RUN_W      = 5;
	localparam int unsigned WLEN_W     = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 15;
	localparam int unsigned SQ_W       = 20;

	localparam int unsigned VAR_SCALE = 10;

	localparam logic [VAR_W-1:0] VAR_MAX     = 15'd32767;
	localparam logic [RUN_W-1:0] WARN_AT_RUN = 5'd15;
	localparam logic [RUN_W-1:0] RUN_MAX     = 5'd31;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_LIMIT = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MEAN_DIV,
		ST_VAR,
		ST_VAR_DIV,
		ST_FINISH
	} wmv_state_t;

endpackage
`default_nettype wire

// ----- design/wmv_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module wmv_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- design/wmv_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module wmv_div #(
	parameter int DW = 29,
	parameter int VW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic      [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW-1:0]    dvd_q;
	logic [VW-1:0]    dvs_q;
	logic [VW-1:0]    rem_q;
	logic [VW:0]      rem_sh;
	logic [VW:0]      rem_nx;
	logic             q_bit;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DW-1]};
		q_bit  = (rem_sh >= {1'b0, dvs_q});
		rem_nx = q_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], q_bit};
			rem_q <= rem_nx[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

// ----- design/window_mean_variance_monitor.sv -----
// Top level of the sliding window mean and variance monitor.
// Each accepted sample is written into a ring of RING_DEPTH entries, and the block then
// reports the truncated mean of the newest window_len entries and ten times their variance
// about that mean, saturated at 32767, plus a one-shot warning on the sixteenth consecutive
// over-limit sample. The window length is clamped to 1..RING_DEPTH, and the divider width DW
// is 24 + log2 of RING_DEPTH, 29 by default. A new sample is accepted only after the previous
// one has been carried through to the output. The pace is set by the single read port of the
// ring RAM, read once per window entry in each of two passes, and by the bit-serial divider
// that is shared by the mean and the variance. The ring reads as zero after reset through
// per-entry valid bits, so no clearing pass is needed. A new sample is taken while the
// previous result still waits at the output, but a finished result, and with it the input,
// is held until the result before it has been taken.
`default_nettype none
module window_mean_variance_monitor #(
	parameter int RING_DEPTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [wmv_pkg::SAMPLE_W-1:0]          sample,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic      [wmv_pkg::MEAN_W-1:0]            window_mean,
	output logic      [wmv_pkg::VAR_W-1:0]             scaled_variance,
	output logic                                       unsteady_warning,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [wmv_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [wmv_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int NW = $clog2(RING_DEPTH + 1);
	localparam int SW = wmv_pkg::SAMPLE_W + AW;
	localparam int QW = wmv_pkg::SQ_W + AW;
	localparam int DW = QW + 4;
	localparam int CW = (NW > wmv_pkg::WLEN_W) ? NW : wmv_pkg::WLEN_W;

	wmv_pkg::wmv_state_t state_q, state_d;

	logic [AW-1:0]                    wp_q;
	logic [AW-1:0]                    newest_q;
	logic [AW-1:0]                    rd_q;
	logic [RING_DEPTH-1:0]            vld_q;
	logic [NW-1:0]                    n_q;
	logic [NW-1:0]                    n_eff;
	logic [NW-1:0]                    iss_q;
	logic                             rd_pend_s1;
	logic                             rd_vld_s1;
	logic                             sq_pend_s2;
	logic [wmv_pkg::SQ_W-1:0]         sq_s2;
	logic [SW-1:0]                    total_q;
	logic [QW-1:0]                    sqsum_q;
	logic [wmv_pkg::MEAN_W-1:0]       mean_q;
	logic [wmv_pkg::VAR_W-1:0]        var_q;
	logic [wmv_pkg::RUN_W-1:0]        run_q;
	logic [wmv_pkg::WLEN_W-1:0]       window_len_q;
	logic [wmv_pkg::VAR_W-1:0]        variance_limit_q;
	logic                             out_valid_q;
	logic [wmv_pkg::MEAN_W-1:0]       window_mean_q;
	logic [wmv_pkg::VAR_W-1:0]        scaled_variance_q;
	logic                             unsteady_warning_q;

	logic [wmv_pkg::SAMPLE_W-1:0]     ram_rdata;
	logic [wmv_pkg::SAMPLE_W-1:0]     smp;
	logic [CW-1:0]                    wl_ext;
	logic                             accept_in;
	logic                             issue;
	logic                             pass_done;
	logic                             out_load;
	logic                             div_start;
	logic                             div_done;
	logic [DW-1:0]                    div_dividend;
	logic [DW-1:0]                    div_quotient;
	logic signed [wmv_pkg::SAMPLE_W:0] diff;
	logic signed [2*wmv_pkg::SAMPLE_W+1:0] prod;
	logic                             over;

	wmv_ram #(
		.WIDTH(wmv_pkg::SAMPLE_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (accept_in),
		.waddr(wp_q),
		.wdata(sample),
		.raddr(rd_q),
		.rdata(ram_rdata)
	);

	wmv_div #(
		.DW(DW),
		.VW(NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (n_q),
		.done    (div_done),
		.quotient(div_quotient)
	);

	assign in_ready  = (state_q == wmv_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept_in = in_valid && in_ready;
	assign issue     = ((state_q == wmv_pkg::ST_SUM) || (state_q == wmv_pkg::ST_VAR))
	                   && (iss_q != n_q);
	assign pass_done = (iss_q == n_q) && !rd_pend_s1 && !sq_pend_s2;
	assign out_load  = (state_q == wmv_pkg::ST_FINISH) && (!out_valid_q || out_ready);
	assign smp       = rd_vld_s1 ? ram_rdata : '0;
	assign diff      = $signed({1'b0, smp}) - $signed({1'b0, mean_q});
	assign prod      = diff * diff;
	assign over      = (var_q > variance_limit_q);

	assign div_dividend = (state_q == wmv_pkg::ST_SUM) ? DW'(total_q)
	                      : DW'(sqsum_q) * DW'(wmv_pkg::VAR_SCALE);

	always_comb begin
		wl_ext = CW'(window_len_q);
		if (wl_ext == '0) begin
			n_eff = NW'(1);
		end else if (wl_ext > CW'(RING_DEPTH)) begin
			n_eff = NW'(RING_DEPTH);
		end else begin
			n_eff = NW'(wl_ext);
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			wmv_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = wmv_pkg::ST_SUM;
				end
			end
			wmv_pkg::ST_SUM: begin
				if (pass_done) begin
					div_start = 1'b1;
					state_d   = wmv_pkg::ST_MEAN_DIV;
				end
			end
			wmv_pkg::ST_MEAN_DIV: begin
				if (div_done) begin
					state_d = wmv_pkg::ST_VAR;
				end
			end
			wmv_pkg::ST_VAR: begin
				if (pass_done) begin
					div_start = 1'b1;
					state_d   = wmv_pkg::ST_VAR_DIV;
				end
			end
			wmv_pkg::ST_VAR_DIV: begin
				if (div_done) begin
					state_d = wmv_pkg::ST_FINISH;
				end
			end
			wmv_pkg::ST_FINISH: begin
				if (out_load) begin
					state_d = wmv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wmv_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q             <= '0;
			newest_q         <= '0;
			rd_q             <= '0;
			vld_q            <= '0;
			n_q              <= NW'(1);
			iss_q            <= '0;
			rd_pend_s1       <= 1'b0;
			sq_pend_s2       <= 1'b0;
			run_q            <= '0;
			out_valid_q      <= 1'b0;
			window_len_q     <= 6'd16;
			variance_limit_q <= 15'd1000;
		end else begin
			rd_pend_s1 <= issue;
			sq_pend_s2 <= rd_pend_s1 && (state_q == wmv_pkg::ST_VAR);
			if (accept_in) begin
				wp_q         <= (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				newest_q     <= wp_q;
				rd_q         <= wp_q;
				vld_q[wp_q]  <= 1'b1;
				n_q          <= n_eff;
				iss_q        <= '0;
			end else if (issue) begin
				rd_q  <= (rd_q == '0) ? AW'(RING_DEPTH - 1) : rd_q - 1'b1;
				iss_q <= iss_q + 1'b1;
			end else if ((state_q == wmv_pkg::ST_MEAN_DIV) && div_done) begin
				rd_q  <= newest_q;
				iss_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (over) begin
					if (run_q < wmv_pkg::RUN_MAX) begin
						run_q <= run_q + 1'b1;
					end
				end else begin
					run_q <= '0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					wmv_pkg::CFG_WINDOW_LEN: begin
						window_len_q <= cfg_data[wmv_pkg::WLEN_W-1:0];
					end
					wmv_pkg::CFG_VARIANCE_LIMIT: begin
						variance_limit_q <= cfg_data[wmv_pkg::VAR_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_s1 <= vld_q[rd_q];
		sq_s2     <= prod[wmv_pkg::SQ_W-1:0];
		if (accept_in) begin
			total_q <= '0;
			sqsum_q <= '0;
		end else begin
			if (rd_pend_s1 && (state_q == wmv_pkg::ST_SUM)) begin
				total_q <= total_q + SW'(smp);
			end
			if (sq_pend_s2) begin
				sqsum_q <= sqsum_q + QW'(sq_s2);
			end
		end
		if ((state_q == wmv_pkg::ST_MEAN_DIV) && div_done) begin
			mean_q <= div_quotient[wmv_pkg::MEAN_W-1:0];
		end
		if ((state_q == wmv_pkg::ST_VAR_DIV) && div_done) begin
			var_q <= (|div_quotient[DW-1:wmv_pkg::VAR_W]) ? wmv_pkg::VAR_MAX
			         : div_quotient[wmv_pkg::VAR_W-1:0];
		end
		if (out_load) begin
			window_mean_q      <= mean_q;
			scaled_variance_q  <= var_q;
			unsteady_warning_q <= over && (run_q == wmv_pkg::WARN_AT_RUN);
		end
	end

	assign out_valid        = out_valid_q;
	assign window_mean      = window_mean_q;
	assign scaled_variance  = scaled_variance_q;
	assign unsteady_warning = unsteady_warning_q;

	a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == wmv_pkg::ST_MEAN_DIV || state_q == wmv_pkg::ST_VAR_DIV))
		else $error("Divider finished outside a division state.");

	a_issue_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		iss_q <= n_q)
		else $error("Ring read count passed the window length.");

	a_warn_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && unsteady_warning_q) |-> (run_q == wmv_pkg::WARN_AT_RUN + 5'd1))
		else $error("Warning shown without a run of sixteen.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> !in_ready)
		else $error("Input ready right after an accepted transaction.");

endmodule
`default_nettype wire
